// ===== hdl/setc_pkg.sv =====
package setc_pkg;

  // Default sizes
  localparam int RING_DEPTH_DEF  = 2048;
  localparam int FRAME_LEN_DEF   = 128;
  localparam int SAMPLE_BITS_DEF = 10;

  // Register port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int MISS_W     = 8;

  // Register indexes
  localparam logic [2:0] REG_LEVEL      = 3'd0;
  localparam logic [2:0] REG_BAND       = 3'd1;
  localparam logic [2:0] REG_RISING     = 3'd2;
  localparam logic [2:0] REG_START_BACK = 3'd3;
  localparam logic [2:0] REG_LIMIT      = 3'd4;
  localparam logic [2:0] REG_PRETRIG    = 3'd5;
  localparam logic [2:0] REG_AUTO_AFTER = 3'd6;

  // Register reset values
  localparam int RST_LEVEL      = 515;
  localparam int RST_BAND       = 2;
  localparam int RST_START_BACK = 68;
  localparam int RST_LIMIT      = 956;
  localparam int RST_PRETRIG    = 64;
  localparam int RST_AUTO_AFTER = 5;

  // Request functions
  localparam logic [1:0] FN_PUSH   = 2'd0;
  localparam logic [1:0] FN_SEARCH = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  // Result kinds and search status codes
  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [1:0] ST_TRIG  = 2'd0;
  localparam logic [1:0] ST_AUTO  = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  typedef struct packed {
    logic push;
    logic start_search;
    logic start_read;
    logic search_run;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } dp_status_t;

endpackage

// ===== hdl/setc_regs.sv =====
module setc_regs
  import setc_pkg::*;
#(
  parameter int AW = 11,
  parameter int SB = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [SB-1:0]         trigger_level,
  output logic [SB-1:0]         trigger_band,
  output logic                  rise_mode,
  output logic [AW-1:0]         search_start_back,
  output logic [AW-1:0]         search_limit,
  output logic [AW-1:0]         pretrigger,
  output logic [MISS_W-1:0]     auto_after
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level     <= SB'(RST_LEVEL);
      trigger_band      <= SB'(RST_BAND);
      rise_mode         <= 1'b0;
      search_start_back <= AW'(RST_START_BACK);
      search_limit      <= AW'(RST_LIMIT);
      pretrigger        <= AW'(RST_PRETRIG);
      auto_after        <= MISS_W'(RST_AUTO_AFTER);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEVEL:      trigger_level     <= pwdata[SB-1:0];
        REG_BAND:       trigger_band      <= pwdata[SB-1:0];
        REG_RISING:     rise_mode         <= pwdata[0];
        REG_START_BACK: search_start_back <= pwdata[AW-1:0];
        REG_LIMIT:      search_limit      <= pwdata[AW-1:0];
        REG_PRETRIG:    pretrigger        <= pwdata[AW-1:0];
        REG_AUTO_AFTER: auto_after        <= pwdata[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_LEVEL:      prdata = APB_DATA_W'(trigger_level);
      REG_BAND:       prdata = APB_DATA_W'(trigger_band);
      REG_RISING:     prdata = APB_DATA_W'(rise_mode);
      REG_START_BACK: prdata = APB_DATA_W'(search_start_back);
      REG_LIMIT:      prdata = APB_DATA_W'(search_limit);
      REG_PRETRIG:    prdata = APB_DATA_W'(pretrigger);
      REG_AUTO_AFTER: prdata = APB_DATA_W'(auto_after);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hdl/setc_ctrl.sv =====
module setc_ctrl
  import setc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] func,
  output logic       res_valid,
  input  logic       res_ready,
  input  dp_status_t status_in,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SEND   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       out_free;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign out_free  = !res_valid || res_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FN_PUSH: cmd.push = 1'b1;
            FN_SEARCH: begin
              cmd.start_search = 1'b1;
              state_next       = S_SEARCH;
            end
            FN_READ: begin
              cmd.start_read = 1'b1;
              state_next     = S_SEND;
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        cmd.search_run = 1'b1;
        if (status_in.hit || status_in.exhausted) begin
          cmd.commit = 1'b1;
          state_next = S_SEND;
        end
      end
      S_SEND: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/setc_dp.sv =====
module setc_dp
  import setc_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int FRAME_LEN   = FRAME_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ctrl_cmd_t                    cmd,
  output dp_status_t                   status_out,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [$clog2(FRAME_LEN)-1:0] frame_offset,
  input  logic [SAMPLE_BITS-1:0]       trigger_level,
  input  logic [SAMPLE_BITS-1:0]       trigger_band,
  input  logic                         rise_mode,
  input  logic [$clog2(RING_DEPTH)-1:0] search_start_back,
  input  logic [$clog2(RING_DEPTH)-1:0] search_limit,
  input  logic [$clog2(RING_DEPTH)-1:0] pretrigger,
  input  logic [MISS_W-1:0]            auto_after,
  output logic                         kind,
  output logic [1:0]                   status,
  output logic [$clog2(RING_DEPTH)-1:0] frame_begin,
  output logic [$clog2(RING_DEPTH)-1:0] hit_index,
  output logic [SAMPLE_BITS-1:0]       sample_value
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int SB    = SAMPLE_BITS;
  localparam int OW    = $clog2(FRAME_LEN);
  localparam int SUM_W = (AW > OW) ? AW : OW;
  localparam logic [AW-1:0] FRAME_BACK = AW'(FRAME_LEN % RING_DEPTH);

  // Ring storage, filled from index zero upward after reset
  logic [SB-1:0] ring [RING_DEPTH];
  logic [AW:0]   fill;
  logic [AW-1:0] newest_pos;
  logic [AW-1:0] push_addr;

  // Control-side state
  logic [MISS_W-1:0] miss_run;
  logic [MISS_W-1:0] miss_inc;
  logic [AW-1:0]     frame_pos;

  // Search walk
  logic [AW-1:0] walk_pos;
  logic [AW-1:0] left;
  logic          eval_valid;
  logic [AW-1:0] eval_pos;

  // Registered read ports
  logic          rd_en;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] read_addr;
  logic [SB-1:0] rd_cur;
  logic [SB-1:0] rd_old;
  logic          cur_ok;
  logic          old_ok;

  // Pending result
  logic          res_kind;
  logic [1:0]    res_status;
  logic [AW-1:0] res_hit;

  logic [SB-1:0] cur_val;
  logic [SB-1:0] old_val;
  logic [SB-1:0] gap;
  logic          edge_ok;
  logic          hit;

  function automatic logic written(input logic [AW:0] cnt, input logic [AW-1:0] a);
    written = cnt[AW] || ({1'b0, a} < cnt);
  endfunction

  assign push_addr = newest_pos + AW'(1);
  assign read_addr = AW'(SUM_W'(frame_pos) + SUM_W'(frame_offset));
  assign addr_a    = cmd.start_read ? read_addr : walk_pos;
  assign addr_b    = walk_pos - AW'(1);
  assign rd_en     = cmd.start_read || (cmd.search_run && (left != '0));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring[push_addr] <= sample;
    end
    if (rd_en) begin
      rd_cur <= ring[addr_a];
      rd_old <= ring[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_ok <= written(fill, addr_a);
      old_ok <= written(fill, addr_b);
    end
  end

  // Hit test on the pair read last cycle
  assign cur_val = cur_ok ? rd_cur : '0;
  assign old_val = old_ok ? rd_old : '0;
  assign gap     = (cur_val >= trigger_level) ? (cur_val - trigger_level)
                                              : (trigger_level - cur_val);
  assign edge_ok = rise_mode ? (old_val < cur_val) : (old_val > cur_val);
  assign hit     = eval_valid && edge_ok && (gap < trigger_band);

  assign status_out.hit       = hit;
  assign status_out.exhausted = (left == '0) && !eval_valid;

  assign miss_inc = (miss_run == '1) ? miss_run : miss_run + MISS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      newest_pos <= '1;
      miss_run   <= '0;
      frame_pos  <= '0;
      eval_valid <= 1'b0;
      left       <= '0;
    end else begin
      if (cmd.push) begin
        newest_pos <= push_addr;
        if (!fill[AW]) begin
          fill <= fill + (AW+1)'(1);
        end
      end
      if (cmd.start_search) begin
        walk_pos   <= newest_pos - search_start_back;
        left       <= search_limit;
        eval_valid <= 1'b0;
      end else if (cmd.search_run) begin
        eval_valid <= (left != '0);
        eval_pos   <= walk_pos;
        if (left != '0) begin
          walk_pos <= walk_pos - AW'(1);
          left     <= left - AW'(1);
        end
      end
      if (cmd.commit) begin
        if (hit) begin
          frame_pos <= eval_pos - pretrigger;
          miss_run  <= '0;
        end else if (miss_inc >= auto_after) begin
          frame_pos <= newest_pos - FRAME_BACK;
          miss_run  <= '0;
        end else begin
          miss_run <= miss_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      res_kind <= KIND_SEARCH;
    end else if (cmd.start_read) begin
      res_kind <= KIND_READ;
    end
    if (cmd.commit) begin
      if (hit) begin
        res_status <= ST_TRIG;
        res_hit    <= eval_pos;
      end else begin
        res_status <= (miss_inc >= auto_after) ? ST_AUTO : ST_NONE;
        res_hit    <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind        <= res_kind;
      frame_begin <= frame_pos;
      if (res_kind == KIND_READ) begin
        status       <= ST_TRIG;
        hit_index    <= '0;
        sample_value <= cur_val;
      end else begin
        status       <= res_status;
        hit_index    <= res_hit;
        sample_value <= '0;
      end
    end
  end

endmodule

// ===== hdl/scope_edge_trigger_capture.sv =====
// Edge-triggered capture ring with auto trigger.
//
// Requests arrive on req_valid/req_ready with func, sample and frame_offset.
// A push (func 0) stores the sample in the ring and gives no result;
// pushes stream at one per cycle while the block is idle. func 3 is
// dropped. A frame read (func 2) registers the ring entry, then loads the
// output register, and holds off the next request until that load. A
// search (func 1) walks the ring backward, one position per cycle through
// the ring's two read ports, for up to search_limit positions, and stops
// early on a hit; no request is taken until its result is loaded.
// Results leave on res_valid/res_ready from an output register; while a
// result waits, the block keeps taking pushes, and a search or read runs to
// completion and then holds until the output register frees up.
// Reset loads the register defaults, empties the ring (entries not yet
// pushed since reset read as zero, tracked by a fill count, so no clearing
// pass is needed), clears the miss count and the frame position.
// Configuration goes through the APB port; write it only while idle.
module scope_edge_trigger_capture
  import setc_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int FRAME_LEN   = FRAME_LEN_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    func,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [$clog2(FRAME_LEN)-1:0]  frame_offset,
  // Result channel
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          kind,
  output logic [1:0]                    status,
  output logic [$clog2(RING_DEPTH)-1:0] frame_begin,
  output logic [$clog2(RING_DEPTH)-1:0] hit_index,
  output logic [SAMPLE_BITS-1:0]        sample_value,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready
);

  localparam int AW = $clog2(RING_DEPTH);

  // Register values
  logic [SAMPLE_BITS-1:0] trigger_level;
  logic [SAMPLE_BITS-1:0] trigger_band;
  logic                   rise_mode;
  logic [AW-1:0]          search_start_back;
  logic [AW-1:0]          search_limit;
  logic [AW-1:0]          pretrigger;
  logic [MISS_W-1:0]      auto_after;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  setc_regs #(
    .AW (AW),
    .SB (SAMPLE_BITS)
  ) u_regs (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .trigger_level     (trigger_level),
    .trigger_band      (trigger_band),
    .rise_mode         (rise_mode),
    .search_start_back (search_start_back),
    .search_limit      (search_limit),
    .pretrigger        (pretrigger),
    .auto_after        (auto_after)
  );

  // Sequence requests: push, start a walk, or start a read, and send the result of a walk or read
  setc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .func      (func),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .status_in (dp_status),
    .cmd       (cmd)
  );

  // Ring, walk pointer, hit test, frame state and output register
  setc_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .FRAME_LEN   (FRAME_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status_out        (dp_status),
    .sample            (sample),
    .frame_offset      (frame_offset),
    .trigger_level     (trigger_level),
    .trigger_band      (trigger_band),
    .rise_mode         (rise_mode),
    .search_start_back (search_start_back),
    .search_limit      (search_limit),
    .pretrigger        (pretrigger),
    .auto_after        (auto_after),
    .kind              (kind),
    .status            (status),
    .frame_begin       (frame_begin),
    .hit_index         (hit_index),
    .sample_value      (sample_value)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import setc_pkg::*;

  localparam int RING_AW    = $clog2(RING_DEPTH_DEF);
  localparam int OFF_W      = $clog2(FRAME_LEN_DEF);
  localparam int SW         = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX = (1 << SW) - 1;
  localparam int QUIET_GAP  = 8;
  localparam int N_PHASES   = 12;
  localparam int MAX_PRINTS = 40;

  // func code 3 has no meaning; the block must drop it silently
  localparam logic [1:0] FN_IGNORED = 2'd3;

  typedef struct {
    logic [1:0]       func;
    logic [SW-1:0]    value;
    logic [OFF_W-1:0] offset;
    bit               drain_first;
  } scope_req_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic [RING_AW-1:0] frame_begin;
    logic [RING_AW-1:0] hit_index;
    logic [SW-1:0]      sample_value;
  } readout_t;

  // Stimulus and DUT ports; every input starts at a known value
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [1:0]         func = '0;
  logic [SW-1:0]      sample = '0;
  logic [OFF_W-1:0]   frame_offset = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic               kind;
  logic [1:0]         status;
  logic [RING_AW-1:0] frame_begin;
  logic [RING_AW-1:0] hit_index;
  logic [SW-1:0]      sample_value;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic               pready;

  scope_edge_trigger_capture dut (.*);

  always #10 clk = ~clk;

  // Shadow copy of the capture ring and trigger state
  logic [SW-1:0]      ring_copy [RING_DEPTH_DEF];
  logic [RING_AW-1:0] newest_idx;
  logic [RING_AW-1:0] frame_start;
  int unsigned        miss_count;

  // Shadow copy of the trigger setup registers
  logic [9:0]  level_cfg;
  logic [9:0]  band_cfg;
  logic        rising_cfg;
  logic [10:0] start_back_cfg;
  logic [10:0] walk_limit_cfg;
  logic [10:0] pretrig_cfg;
  logic [7:0]  auto_after_cfg;

  scope_req_t req_queue[$];
  readout_t   owed[$];
  scope_req_t held;
  readout_t   seen, want;
  bit         settled = 1'b1;
  bit         drain_next;
  int         queued;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int mismatches = 0;
  int checked = 0;
  int n_push = 0, n_read = 0, n_trig = 0, n_auto = 0, n_none = 0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Apply one accepted request to the shadow state and queue the readout it owes
  function automatic void step_capture(input scope_req_t rq);
    readout_t           res;
    logic [RING_AW-1:0] pos, hit_pos;
    bit                 found;
    int                 cur, older, gap;
    int unsigned        n;
    res = '0;
    found = 1'b0;
    hit_pos = '0;
    case (rq.func)
      FN_PUSH: begin
        newest_idx = newest_idx + 1'b1;
        ring_copy[newest_idx] = rq.value;
        n_push++;
      end
      FN_SEARCH: begin
        pos = newest_idx - start_back_cfg;
        for (n = 0; n < walk_limit_cfg && !found; n++) begin
          cur = int'(ring_copy[pos]);
          older = int'(ring_copy[pos - 1'b1]);
          gap = cur - int'(level_cfg);
          if (gap < 0) gap = -gap;
          if ((rising_cfg ? older < cur : older > cur) && gap < int'(band_cfg)) begin
            found = 1'b1;
            hit_pos = pos;
          end else begin
            pos = pos - 1'b1;
          end
        end
        if (found) begin
          frame_start = hit_pos - pretrig_cfg;
          miss_count = 0;
          res.status = ST_TRIG;
          res.hit_index = hit_pos;
          n_trig++;
        end else begin
          if (miss_count < 255) miss_count++;
          if (miss_count >= auto_after_cfg) begin
            // auto trigger: show the newest frame
            frame_start = newest_idx - RING_AW'(FRAME_LEN_DEF);
            miss_count = 0;
            res.status = ST_AUTO;
            n_auto++;
          end else begin
            res.status = ST_NONE;
            n_none++;
          end
        end
        res.kind = KIND_SEARCH;
        res.frame_begin = frame_start;
        owed.push_back(res);
      end
      FN_READ: begin
        pos = frame_start + rq.offset;
        res.kind = KIND_READ;
        res.frame_begin = frame_start;
        res.sample_value = ring_copy[pos];
        owed.push_back(res);
        n_read++;
      end
      default: ;
    endcase
  endfunction

  // Request driver: take a request at each handshake, then offer the next one
  always @(posedge clk) begin : drive_requests
    bit go;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) step_capture(held);
      if (!req_valid || req_ready) begin
        go = req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
        // hold a drain-marked request until every owed readout is back
        if (go && req_queue[0].drain_first && !(settled && !(req_valid && req_ready)))
          go = 1'b0;
        if (go) begin
          held = req_queue.pop_front();
          req_valid <= 1'b1;
          func <= held.func;
          sample <= held.value;
          frame_offset <= held.offset;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) settled <= (owed.size() == 0);

  // Result monitor: compare each accepted readout with the oldest one owed
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        seen = {kind, status, frame_begin, hit_index, sample_value};
        if (owed.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d status %0d begin %0d",
                                  kind, status, frame_begin));
        end else begin
          want = owed.pop_front();
          checked++;
          if (seen.kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", seen.kind, want.kind));
          if (seen.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", seen.status, want.status));
          if (seen.frame_begin !== want.frame_begin)
            flag_mismatch($sformatf("frame_begin %0d, want %0d",
                                    seen.frame_begin, want.frame_begin));
          if (seen.hit_index !== want.hit_index)
            flag_mismatch($sformatf("hit_index %0d, want %0d",
                                    seen.hit_index, want.hit_index));
          if (seen.sample_value !== want.sample_value)
            flag_mismatch($sformatf("sample_value %0d, want %0d",
                                    seen.sample_value, want.sample_value));
        end
      end
      res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Queue one request; func 3 does not count toward the phase total
  task automatic add_req(input logic [1:0] f, input int v, input int off);
    scope_req_t rq;
    rq.func = f;
    rq.value = SW'(v);
    rq.offset = OFF_W'(off);
    rq.drain_first = drain_next;
    drain_next = 1'b0;
    req_queue.push_back(rq);
    if (f != FN_IGNORED) queued++;
  endtask

  // Write one setup register through APB and mirror it
  task automatic write_reg(input logic [2:0] idx, input int val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LEVEL:      level_cfg = val[9:0];
      REG_BAND:       band_cfg = val[9:0];
      REG_RISING:     rising_cfg = val[0];
      REG_START_BACK: start_back_cfg = val[10:0];
      REG_LIMIT:      walk_limit_cfg = val[10:0];
      REG_PRETRIG:    pretrig_cfg = val[10:0];
      REG_AUTO_AFTER: auto_after_cfg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int lvl, input int band, input int rise, input int back,
                            input int lim, input int pre, input int auto_n);
    write_reg(REG_LEVEL, lvl);
    write_reg(REG_BAND, band);
    write_reg(REG_RISING, rise);
    write_reg(REG_START_BACK, back);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_PRETRIG, pre);
    write_reg(REG_AUTO_AFTER, auto_n);
  endtask

  // Wait until every request is taken and every readout is back, then let
  // any trailing push settle inside the block
  task automatic wait_quiet();
    do @(negedge clk); while (req_queue.size() != 0 || req_valid || owed.size() != 0);
    repeat (QUIET_GAP) @(negedge clk);
  endtask

  function automatic int pick_offset();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return FRAME_LEN_DEF - 1;
      default: return $urandom_range(0, FRAME_LEN_DEF - 1);
    endcase
  endfunction

  // Mostly edge-crossing bursts followed by a search and a few frame reads,
  // mixed with lone searches, lone reads, noise pushes and dropped codes
  task automatic fill_random(input int n_items);
    int r, k, step, tail, dir, v, i, span;
    queued = 0;
    drain_next = 1'b1;
    while (queued < n_items) begin
      if ($urandom_range(0, 99) < 3) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        repeat ($urandom_range(0, 6))
          add_req(FN_PUSH, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, FRAME_LEN_DEF - 1));
        dir = rising_cfg ? 1 : -1;
        if ($urandom_range(0, 3) == 0) dir = -dir;
        k = $urandom_range(3, 12);
        span = (band_cfg == 0) ? 8 : (band_cfg < 64 ? int'(band_cfg) : 64);
        step = $urandom_range(1, span);
        for (i = 0; i < k; i++) begin
          v = int'(level_cfg) + dir * (i - k / 2) * step;
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          add_req(FN_PUSH, v, $urandom_range(0, FRAME_LEN_DEF - 1));
        end
        // place the crossing just within reach of where the walk starts
        tail = (start_back_cfg <= 24) ? int'(start_back_cfg) + $urandom_range(0, 4)
                                      : $urandom_range(0, 8);
        repeat (tail)
          add_req(FN_PUSH, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, FRAME_LEN_DEF - 1));
        add_req(FN_SEARCH, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, FRAME_LEN_DEF - 1));
        repeat ($urandom_range(0, 3))
          add_req(FN_READ, $urandom_range(0, SAMPLE_MAX), pick_offset());
      end else if (r < 72) begin
        add_req(FN_SEARCH, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, FRAME_LEN_DEF - 1));
      end else if (r < 88) begin
        add_req(FN_READ, $urandom_range(0, SAMPLE_MAX), pick_offset());
      end else if (r < 97) begin
        repeat ($urandom_range(1, 10))
          add_req(FN_PUSH, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, FRAME_LEN_DEF - 1));
      end else begin
        add_req(FN_IGNORED, $urandom_range(0, SAMPLE_MAX), $urandom_range(0, FRAME_LEN_DEF - 1));
      end
    end
  endtask

  initial begin
    int phase;
    // Reset-time setup and an empty ring
    level_cfg = RST_LEVEL;
    band_cfg = RST_BAND;
    rising_cfg = 1'b0;
    start_back_cfg = RST_START_BACK;
    walk_limit_cfg = RST_LIMIT;
    pretrig_cfg = RST_PRETRIG;
    auto_after_cfg = RST_AUTO_AFTER;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    newest_idx = '1;
    frame_start = '0;
    miss_count = 0;
    drain_next = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset setup: sample extremes, a search that finds only zeros,
    // reads at both ends of the frame, a dropped code, then misses up to auto
    @(negedge clk);
    add_req(FN_PUSH, 0, 0);
    add_req(FN_PUSH, SAMPLE_MAX, FRAME_LEN_DEF - 1);
    add_req(FN_PUSH, 514, 0);
    add_req(FN_SEARCH, 0, 0);
    add_req(FN_READ, 0, 0);
    add_req(FN_READ, SAMPLE_MAX, FRAME_LEN_DEF - 1);
    add_req(FN_IGNORED, SAMPLE_MAX, FRAME_LEN_DEF - 1);
    repeat (4) add_req(FN_SEARCH, 0, 0);
    add_req(FN_READ, 0, FRAME_LEN_DEF - 1);

    // Directed: a falling edge right at the newest sample, then a rising one
    // one step back with a pretrigger, read through the resulting frames
    wait_quiet();
    set_config(515, 2, 0, 0, 4, 0, 1);
    @(negedge clk);
    add_req(FN_PUSH, SAMPLE_MAX, 0);
    add_req(FN_PUSH, 514, 0);
    add_req(FN_SEARCH, 0, 0);
    add_req(FN_READ, 0, 0);
    add_req(FN_READ, 0, 1);
    wait_quiet();
    set_config(515, 2, 1, 1, 4, 5, 1);
    @(negedge clk);
    add_req(FN_PUSH, 0, 0);
    add_req(FN_PUSH, 516, 0);
    add_req(FN_PUSH, 7, 0);
    add_req(FN_SEARCH, 0, 0);
    add_req(FN_READ, 0, FRAME_LEN_DEF - 1);

    // Random phases: extremes first, then random setups; cycle the idle mix
    for (phase = 0; phase < N_PHASES; phase++) begin
      wait_quiet();
      case (phase)
        0: set_config(0, 1, 1, 0, 1, 0, 1);
        1: set_config(SAMPLE_MAX, SAMPLE_MAX, 0, 2047, 2047, 2047, 255);
        // zero band, zero walk, zero auto threshold: every search auto triggers
        2: set_config($urandom_range(0, SAMPLE_MAX), 0, $urandom_range(0, 1),
                      $urandom_range(0, 24), 0, $urandom_range(0, 2047), 0);
        // full-length walks
        3: set_config($urandom_range(0, SAMPLE_MAX), 1, $urandom_range(0, 1),
                      $urandom_range(0, 2047), 2047, $urandom_range(0, 2047), 255);
        default: set_config($urandom_range(0, SAMPLE_MAX), $urandom_range(1, 48),
                            $urandom_range(0, 1), $urandom_range(0, 24),
                            $urandom_range(1, 160), $urandom_range(0, 2047),
                            ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      @(negedge clk);
      fill_random(phase == 3 ? 100 : 160);
    end

    // Drain, then keep watching the result channel for stray results
    wait_quiet();
    repeat (int'(walk_limit_cfg) + 16) @(posedge clk);

    $display("Covered %0d pushes, %0d frame reads, %0d searches (%0d hit, %0d auto, %0d no frame)",
             n_push, n_read, n_trig + n_auto + n_none, n_trig, n_auto, n_none);
    $display("Checked %0d results over %0d setups, %0d mismatches",
             checked, N_PHASES + 3, mismatches);
    if (mismatches == 0 && owed.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Give up well past the slowest legal run
  initial begin
    #100_000_000;
    $display("Timeout with %0d requests pending and %0d results owed",
             req_queue.size(), owed.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/setc_pkg.sv
hdl/setc_regs.sv
hdl/setc_ctrl.sv
hdl/setc_dp.sv
hdl/scope_edge_trigger_capture.sv
bench/testbench.sv
